### rtl/clm_pkg.sv
package clm_pkg;

	typedef enum logic [1:0] {
		CMD_INS_TAIL = 2'd0,
		CMD_INS_HEAD = 2'd1,
		CMD_DELETE   = 2'd2,
		CMD_LIST     = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_DONE     = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_NOTFOUND = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	// Controller to datapath
	typedef struct packed {
		logic    accept;       // latch the incoming value, read the free-slot stack
		logic    rd_head;      // read the head entry, restart the walk
		logic    advance;      // read the next entry, step the walk
		logic    ins_wr;       // write value and link of the new slot
		logic    ins_link;     // link the old tail, update head/tail/count
		logic    ins_at_head;
		logic    del_remove;   // unlink the current entry
		logic    out_load;
		status_t out_status;
		logic    out_zero;
		logic    out_from_mem;
		logic    out_last;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic empty;
		logic full;
		logic hit;
		logic last_entry;
		logic out_free;
	} dp_stat_t;

endpackage

### rtl/clm_dp.sv
module clm_dp #(
	parameter int CAPACITY = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic signed [31:0]    value,
	input  clm_pkg::dp_cmd_t      dcmd,
	output clm_pkg::dp_stat_t     stat,
	input  logic                  out_stall,
	output logic                  out_valid,
	output logic [1:0]            status,
	output logic signed [31:0]    item_value,
	output logic                  last
);

	localparam int SW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	logic [31:0]   mem_val  [CAPACITY];
	logic [SW-1:0] mem_link [CAPACITY];
	logic [SW-1:0] mem_free [CAPACITY];

	logic [SW-1:0] head_q, tail_q, cur_q, prev_q, slot_q;
	logic [SW-1:0] link_rd_q, free_rd_q;
	logic [31:0]   val_rd_q, key_q;
	logic [CW-1:0] count_q, fresh_q, top_q, steps_q;

	logic          out_valid_q, out_last_q;
	logic [1:0]    out_status_q;
	logic [31:0]   out_value_q;

	logic          use_fresh, rd_en, link_we, steps_zero;
	logic [SW-1:0] new_slot, rd_addr, pop_addr, link_wa, link_wd;
	logic [CW-1:0] steps_inc, top_dec;

	assign use_fresh  = (fresh_q != CAP_C);
	assign new_slot   = use_fresh ? fresh_q[SW-1:0] : free_rd_q;
	assign steps_inc  = steps_q + CW'(1);
	assign steps_zero = (steps_q == '0);
	assign top_dec    = top_q - CW'(1);
	assign pop_addr   = top_dec[SW-1:0];
	assign rd_en      = dcmd.rd_head | dcmd.advance;
	assign rd_addr    = dcmd.rd_head ? head_q : link_rd_q;

	assign stat.empty      = (count_q == '0);
	assign stat.full       = (count_q == CAP_C);
	assign stat.hit        = (val_rd_q == key_q);
	assign stat.last_entry = (steps_inc == count_q);
	assign stat.out_free   = !out_valid_q || !out_stall;

	// one write port on the link store, shared by insert and delete
	always_comb begin
		link_we = 1'b0;
		link_wa = tail_q;
		link_wd = link_rd_q;
		if (dcmd.ins_wr) begin
			link_we = 1'b1;
			link_wa = new_slot;
			link_wd = stat.empty ? new_slot : head_q;
		end else if (dcmd.ins_link) begin
			link_we = !stat.empty;
			link_wa = tail_q;
			link_wd = slot_q;
		end else if (dcmd.del_remove) begin
			if (steps_zero) begin
				link_we = (count_q != CW'(1));
				link_wa = tail_q;
			end else begin
				link_we = 1'b1;
				link_wa = prev_q;
			end
			link_wd = link_rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (dcmd.ins_wr) begin
			mem_val[new_slot] <= key_q;
		end
		if (rd_en) begin
			val_rd_q <= mem_val[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (link_we) begin
			mem_link[link_wa] <= link_wd;
		end
		if (rd_en) begin
			link_rd_q <= mem_link[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (dcmd.del_remove) begin
			mem_free[top_q[SW-1:0]] <= cur_q;
		end
		if (dcmd.accept) begin
			free_rd_q <= mem_free[pop_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (dcmd.accept) begin
			key_q <= value;
		end
		if (dcmd.rd_head) begin
			cur_q   <= head_q;
			steps_q <= '0;
		end else if (dcmd.advance) begin
			prev_q  <= cur_q;
			cur_q   <= link_rd_q;
			steps_q <= steps_inc;
		end
		if (dcmd.ins_wr) begin
			slot_q <= new_slot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			fresh_q <= '0;
			top_q   <= '0;
		end else begin
			if (dcmd.ins_wr) begin
				if (use_fresh) begin
					fresh_q <= fresh_q + CW'(1);
				end else begin
					top_q <= top_dec;
				end
			end
			if (dcmd.ins_link) begin
				count_q <= count_q + CW'(1);
				if (stat.empty) begin
					head_q <= slot_q;
					tail_q <= slot_q;
				end else if (dcmd.ins_at_head) begin
					head_q <= slot_q;
				end else begin
					tail_q <= slot_q;
				end
			end
			if (dcmd.del_remove) begin
				top_q   <= top_q + CW'(1);
				count_q <= count_q - CW'(1);
				if (steps_zero) begin
					if (count_q == CW'(1)) begin
						head_q <= '0;
						tail_q <= '0;
					end else begin
						head_q <= link_rd_q;
					end
				end else if (cur_q == tail_q) begin
					tail_q <= prev_q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (dcmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (dcmd.out_load) begin
			out_status_q <= dcmd.out_status;
			out_last_q   <= dcmd.out_last;
			if (dcmd.out_from_mem) begin
				out_value_q <= val_rd_q;
			end else if (dcmd.out_zero) begin
				out_value_q <= '0;
			end else begin
				out_value_q <= key_q;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = out_status_q;
	assign item_value = out_value_q;
	assign last       = out_last_q;

endmodule

### rtl/clm_ctrl.sv
module clm_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         cmd,
	input  clm_pkg::dp_stat_t  stat,
	output clm_pkg::dp_cmd_t   dcmd
);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_INS  = 6'b000010,
		S_LINK = 6'b000100,
		S_DEL  = 6'b001000,
		S_LST  = 6'b010000,
		S_RESP = 6'b100000
	} state_t;

	state_t            state_q, state_d;
	clm_pkg::status_t  resp_q, resp_d;
	logic              zero_q, zero_d;
	logic              at_head_q, at_head_d;
	clm_pkg::cmd_t     cmd_e;

	assign cmd_e    = clm_pkg::cmd_t'(cmd);
	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d   = state_q;
		resp_d    = resp_q;
		zero_d    = zero_q;
		at_head_d = at_head_q;

		dcmd              = '0;
		dcmd.ins_at_head  = at_head_q;
		dcmd.out_status   = resp_q;
		dcmd.out_zero     = zero_q;
		dcmd.out_last     = 1'b1;

		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					dcmd.accept = 1'b1;
					zero_d      = 1'b0;
					unique case (cmd_e) inside
						clm_pkg::CMD_INS_TAIL, clm_pkg::CMD_INS_HEAD: begin
							at_head_d = (cmd_e == clm_pkg::CMD_INS_HEAD);
							if (stat.full) begin
								resp_d  = clm_pkg::ST_FULL;
								state_d = S_RESP;
							end else begin
								state_d = S_INS;
							end
						end
						clm_pkg::CMD_DELETE: begin
							if (stat.empty) begin
								resp_d  = clm_pkg::ST_EMPTY;
								state_d = S_RESP;
							end else begin
								dcmd.rd_head = 1'b1;
								state_d      = S_DEL;
							end
						end
						clm_pkg::CMD_LIST: begin
							if (stat.empty) begin
								resp_d  = clm_pkg::ST_EMPTY;
								zero_d  = 1'b1;
								state_d = S_RESP;
							end else begin
								dcmd.rd_head = 1'b1;
								state_d      = S_LST;
							end
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_INS: begin
				dcmd.ins_wr = 1'b1;
				state_d     = S_LINK;
			end
			S_LINK: begin
				dcmd.ins_link = 1'b1;
				resp_d        = clm_pkg::ST_DONE;
				state_d       = S_RESP;
			end
			S_DEL: begin
				if (stat.hit) begin
					dcmd.del_remove = 1'b1;
					resp_d          = clm_pkg::ST_DONE;
					state_d         = S_RESP;
				end else if (stat.last_entry) begin
					resp_d  = clm_pkg::ST_NOTFOUND;
					state_d = S_RESP;
				end else begin
					dcmd.advance = 1'b1;
				end
			end
			S_LST: begin
				if (stat.out_free) begin
					dcmd.out_load     = 1'b1;
					dcmd.out_status   = clm_pkg::ST_DONE;
					dcmd.out_zero     = 1'b0;
					dcmd.out_from_mem = 1'b1;
					dcmd.out_last     = stat.last_entry;
					if (stat.last_entry) begin
						state_d = S_IDLE;
					end else begin
						dcmd.advance = 1'b1;
					end
				end
			end
			S_RESP: begin
				if (stat.out_free) begin
					dcmd.out_load = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			resp_q    <= clm_pkg::ST_DONE;
			zero_q    <= 1'b0;
			at_head_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			resp_q    <= resp_d;
			zero_q    <= zero_d;
			at_head_q <= at_head_d;
		end
	end

endmodule

### rtl/circular_list_manager_top.sv
// Channel  Handshake            Payload
// in       in_valid / in_stall  cmd[1:0], value[31:0] signed
// out      out_valid / out_stall status[1:0], item_value[31:0] signed, last
//
// Steps: insert passes S_INS and S_LINK, then S_RESP loads the result register;
// delete reads the head, then walks one entry per cycle up to a hit or the last
// entry; a listing gives one result per cycle after a head read, unless out_stall
// holds it. The walk is set by the registered read of the value/link stores.
// Reset: arst_n clears the controller, head, tail, count and free-slot
// bookkeeping at once; no clearing pass, slots are first handed out in order.
// Stalls: out_stall holds the result register and pauses a listing walk;
// in_stall is high while a command is in work.
module circular_list_manager_top #(
	parameter int CAPACITY = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         cmd,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic signed [31:0] item_value,
	output logic               last
);

	clm_pkg::dp_cmd_t  dcmd;
	clm_pkg::dp_stat_t stat;

	// Sequence each command: decode, walk, and hand results to the output register.
	clm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.stat     (stat),
		.dcmd     (dcmd)
	);

	// Hold the slot stores, the free-slot stack, the list pointers and the
	// result register.
	clm_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.value      (value),
		.dcmd       (dcmd),
		.stat       (stat),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.status     (status),
		.item_value (item_value),
		.last       (last)
	);

endmodule
